FILE: rtl/core/lict_pkg.sv
// ----------------------------------------------------------------------------
// lict_pkg
// shared types, register offsets and helpers for the local interrupt
// controller timer slice
// ----------------------------------------------------------------------------
`default_nettype none

package lict_pkg;

    // width of the timer down-counter and of the initial count register
    localparam int COUNT_WIDTH = 32;

    // beat layouts
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;

    // item kinds carried in the op field
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // register offsets, 16-byte aligned
    localparam logic [9:0] OFS_ID    = 10'h020;
    localparam logic [9:0] OFS_TPR   = 10'h080;
    localparam logic [9:0] OFS_EOI   = 10'h0B0;
    localparam logic [9:0] OFS_SVR   = 10'h0F0;
    localparam logic [9:0] OFS_CMDLO = 10'h300;
    localparam logic [9:0] OFS_CMDHI = 10'h310;
    localparam logic [9:0] OFS_TIMER = 10'h320;
    localparam logic [9:0] OFS_LINE0 = 10'h350;
    localparam logic [9:0] OFS_LINE1 = 10'h360;
    localparam logic [9:0] OFS_LINE2 = 10'h370;
    localparam logic [9:0] OFS_INIT  = 10'h380;
    localparam logic [9:0] OFS_CUR   = 10'h390;
    localparam logic [9:0] OFS_DIV   = 10'h3E0;

    // entry bit positions, write masks and reset values
    localparam int PERIODIC_BIT = 17;
    localparam int MASK_BIT     = 16;
    localparam int ENABLE_BIT   = 8;
    localparam logic [17:0] TIMER_KEEP  = 18'h300FF;
    localparam logic [16:0] LINE_KEEP   = 17'h1A7FF;
    localparam logic [3:0]  DIV_KEEP    = 4'hB;
    localparam logic [17:0] TIMER_RESET = 18'h10000;
    localparam logic [16:0] LINE_RESET  = 17'h10000;
    localparam logic [8:0]  SVR_RESET   = 9'h0FF;

    // per-beat control from the register decode into the timer
    typedef struct packed {
        logic                   load;
        logic                   tick;
        logic [COUNT_WIDTH-1:0] load_value;
    } timer_ctl_t;

    // prescaler ratio: bits {3,1,0} give v, ratio 2^(v+1), v = 7 wraps to 1
    function automatic logic [7:0] lict_ratio(input logic [3:0] div_code);
        logic [2:0] shift;
        shift = {div_code[3], div_code[1:0]} + 3'd1;
        return 8'd1 << shift;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lict_timer.sv
// ----------------------------------------------------------------------------
// lict_timer
// prescaler and down-counter with initial count reload
// ----------------------------------------------------------------------------
`default_nettype none

module lict_timer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire lict_pkg::timer_ctl_t            ctl,
    input  wire logic [3:0]                      div_code,
    input  wire logic                            periodic,
    output      logic [lict_pkg::COUNT_WIDTH-1:0] reload_count,
    output      logic [lict_pkg::COUNT_WIDTH-1:0] cur_count,
    output      logic                            expire
);
    import lict_pkg::*;

    logic [COUNT_WIDTH-1:0] init_reg;
    logic [COUNT_WIDTH-1:0] cur_reg;
    logic [6:0]             pre_reg;
    logic [7:0]             pre_inc;
    logic [COUNT_WIDTH-1:0] cur_dec;
    logic                   running;
    logic                   step;

    always_comb begin
        pre_inc = {1'b0, pre_reg} + 8'd1;
        cur_dec = cur_reg - COUNT_WIDTH'(1);
        running = (cur_reg != '0);
        step    = running && (pre_inc >= lict_ratio(div_code));
        expire  = ctl.tick && step && (cur_dec == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= '0;
            cur_reg  <= '0;
            pre_reg  <= '0;
        end else if (ctl.load) begin
            init_reg <= ctl.load_value;
            cur_reg  <= ctl.load_value;
            pre_reg  <= '0;
        end else if (ctl.tick && running) begin
            if (step) begin
                pre_reg <= '0;
                cur_reg <= ((cur_dec == '0) && periodic) ? init_reg : cur_dec;
            end else begin
                pre_reg <= pre_inc[6:0];
            end
        end
    end

    assign reload_count = init_reg;
    assign cur_count    = cur_reg;

endmodule

`default_nettype wire

FILE: rtl/core/local_interrupt_controller_timer_top.sv
// ----------------------------------------------------------------------------
// local_interrupt_controller_timer_top
// register-mapped local interrupt controller slice with timer and ipi issue
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    op, reg_offset, write_data
//  m_*       out  m_tvalid/m_tready    read_data, timer_irq, irq_vector,
//                                      ipi_send, ipi_dest, ipi_vector
//  cfg_*     in   cfg_we               local_id
//
//  one beat per cycle sustained while m_tready is high; each beat passes
//  through the input register and then the result register
//  register file, timer and decode all update in the cycle the beat leaves
//  the input register, so the next beat sees the new state
//  a stall on m_tready holds the result register, then the input register,
//  then drops s_tready
//  aresetn is synchronous, active low; no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module local_interrupt_controller_timer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: local_id
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    // input beats
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // [1:0] op, [11:2] reg_offset, [43:12] write_data, [47:44] zero
    input  wire logic [lict_pkg::IN_TDATA_W-1:0] s_tdata,
    // result beats
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [31:0] read_data, [32] timer_irq, [40:33] irq_vector, [41] ipi_send,
    // [49:42] ipi_dest, [57:50] ipi_vector, [63:58] zero
    output      logic [lict_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lict_pkg::*;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [5:0]  in_ofs_reg;     // offset bits 9..4, low nibble ignored
    logic [31:0] in_data_reg;

    // result register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // architectural registers
    logic [7:0]  local_id_reg;
    logic [7:0]  tpr_reg;
    logic [8:0]  svr_reg;
    logic [17:0] timer_entry_reg;
    logic [16:0] line_reg [3];
    logic [3:0]  div_reg;
    logic [7:0]  cmd_hi_reg;
    logic [7:0]  cmd_lo_reg;

    // beat leaves the input register when the result register can take it
    logic       advance;
    logic [9:0] ofs;
    logic       is_read;
    logic       is_write;
    logic       is_tick;

    timer_ctl_t             tmr_ctl;
    logic [COUNT_WIDTH-1:0] reload_count;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic                   expire;

    logic [31:0] rd_data;
    logic        irq;
    logic        ipi;
    logic [OUT_TDATA_W-1:0] result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign ofs      = {in_ofs_reg, 4'h0};
    assign is_read  = (in_op_reg == OP_READ);
    assign is_write = (in_op_reg == OP_WRITE);
    assign is_tick  = (in_op_reg == OP_TICK);

    // capture incoming beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tdata[1:0];
            in_ofs_reg  <= s_tdata[11:6];
            in_data_reg <= s_tdata[43:12];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_id_reg <= '0;
        end else if (cfg_we) begin
            local_id_reg <= cfg_wdata;
        end
    end

    // timer: loaded by an initial count write, stepped by tick beats
    always_comb begin
        tmr_ctl.load       = advance && is_write && (ofs == OFS_INIT);
        tmr_ctl.tick       = advance && is_tick;
        tmr_ctl.load_value = in_data_reg[COUNT_WIDTH-1:0];
    end

    lict_timer u_timer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (tmr_ctl),
        .div_code     (div_reg),
        .periodic     (timer_entry_reg[PERIODIC_BIT]),
        .reload_count (reload_count),
        .cur_count    (cur_count),
        .expire       (expire)
    );

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpr_reg         <= '0;
            svr_reg         <= SVR_RESET;
            timer_entry_reg <= TIMER_RESET;
            line_reg[0]     <= LINE_RESET;
            line_reg[1]     <= LINE_RESET;
            line_reg[2]     <= LINE_RESET;
            div_reg         <= '0;
            cmd_hi_reg      <= '0;
            cmd_lo_reg      <= '0;
        end else if (advance && is_write) begin
            unique case (ofs)
                OFS_TPR:   tpr_reg         <= in_data_reg[7:0];
                OFS_SVR:   svr_reg         <= in_data_reg[8:0];
                OFS_CMDLO: cmd_lo_reg      <= in_data_reg[7:0];
                OFS_CMDHI: cmd_hi_reg      <= in_data_reg[31:24];
                OFS_TIMER: timer_entry_reg <= in_data_reg[17:0] & TIMER_KEEP;
                OFS_LINE0: line_reg[0]     <= in_data_reg[16:0] & LINE_KEEP;
                OFS_LINE1: line_reg[1]     <= in_data_reg[16:0] & LINE_KEEP;
                OFS_LINE2: line_reg[2]     <= in_data_reg[16:0] & LINE_KEEP;
                OFS_DIV:   div_reg         <= in_data_reg[3:0] & DIV_KEEP;
                default: ;  // eoi, initial count (held in the timer), read-only and unknown offsets
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (ofs)
            OFS_ID:    rd_data = {local_id_reg, 24'h0};
            OFS_TPR:   rd_data = 32'(tpr_reg);
            OFS_SVR:   rd_data = 32'(svr_reg);
            OFS_CMDLO: rd_data = 32'(cmd_lo_reg);
            OFS_CMDHI: rd_data = {cmd_hi_reg, 24'h0};
            OFS_TIMER: rd_data = 32'(timer_entry_reg);
            OFS_LINE0: rd_data = 32'(line_reg[0]);
            OFS_LINE1: rd_data = 32'(line_reg[1]);
            OFS_LINE2: rd_data = 32'(line_reg[2]);
            OFS_INIT:  rd_data = 32'(reload_count);
            OFS_CUR:   rd_data = 32'(cur_count);
            OFS_DIV:   rd_data = 32'(div_reg);
            default:   rd_data = '0;
        endcase
    end

    // result beat assembly
    always_comb begin
        // expiry only delivers when unmasked and software-enabled
        irq = is_tick && expire && !timer_entry_reg[MASK_BIT] && svr_reg[ENABLE_BIT];
        ipi = is_write && (ofs == OFS_CMDLO);
        result = '0;
        result[31:0]  = is_read ? rd_data : 32'h0;
        result[32]    = irq;
        result[40:33] = irq ? timer_entry_reg[7:0] : 8'h0;
        result[41]    = ipi;
        result[49:42] = ipi ? cmd_hi_reg : 8'h0;
        result[57:50] = ipi ? in_data_reg[7:0] : 8'h0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lict_checker.sv
// ----------------------------------------------------------------------------
// lict_checker
// port-level checks on the result channel of the timer slice
// ----------------------------------------------------------------------------
`default_nettype none

module lict_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [lict_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lict_pkg::*;

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // a beat never carries both a timer interrupt and an ipi
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[32] && m_tdata[41]))
        else $error("timer interrupt and ipi in the same beat");

    // vector is zero unless the timer interrupt fires
    a_irq_vec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |-> m_tdata[40:33] == 8'h0)
        else $error("irq vector without timer interrupt");

    // ipi fields are zero unless an ipi is issued
    a_ipi_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[41] |-> m_tdata[57:42] == 16'h0)
        else $error("ipi fields without ipi");

endmodule

bind local_interrupt_controller_timer_top lict_checker u_lict_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
